### hdl/tgp_pkg.sv
// tile grid placement shared types and constants
// no dependencies
package tgp_pkg;

  // configuration register indexes
  localparam logic [0:0] REG_GRID_COLS = 1'b0;
  localparam logic [0:0] REG_GRID_ROWS = 1'b1;

  // one stored tile record
  typedef struct packed {
    logic [7:0] tag;
    logic [4:0] row;
    logic [3:0] col;
    logic [4:0] rspan;
    logic [3:0] cspan;
  } tile_t;

  // front to back command
  typedef struct packed {
    logic       go;
    logic [6:0] count;
  } list_cmd_t;

endpackage

### hdl/tgp_front.sv
// front part: loads tiles into the tile store and hands a list to the back part
// depends on tgp_pkg
module tgp_front #(
  parameter int MAX_TILES = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       tile_tag,
  input  logic             tile_active,
  input  logic [4:0]       want_row,
  input  logic [3:0]       want_col,
  input  logic [4:0]       row_span,
  input  logic [3:0]       col_span,
  input  logic             last_tile,
  output logic             wr_en,
  output logic [$clog2(MAX_TILES+1)-1:0] wr_addr,
  output tgp_pkg::tile_t   wr_data,
  output tgp_pkg::list_cmd_t cmd
);
  import tgp_pkg::*;
  localparam int CW = $clog2(MAX_TILES+1);
  logic [CW-1:0] count;

  // normalize spans of zero
  always_comb begin
    wr_data.tag   = tile_tag;
    wr_data.row   = want_row;
    wr_data.col   = want_col;
    wr_data.rspan = (row_span == 5'd0) ? 5'd1 : row_span;
    wr_data.cspan = (col_span == 4'd0) ? 4'd1 : col_span;
  end

  assign wr_en   = take && tile_active && (count < CW'(MAX_TILES));
  assign wr_addr = count;

  // fill count and list hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cmd   <= '0;
    end else begin
      cmd.go <= 1'b0;
      if (take) begin
        if (last_tile) begin
          cmd.go    <= 1'b1;
          cmd.count <= 7'(count + CW'(wr_en));
          count     <= '0;
        end else if (wr_en) begin
          count <= count + 1'b1;
        end
      end
    end
  end
endmodule

### hdl/tgp_back.sv
// back part: sizes the grid and places stored tiles over the occupancy map
// depends on tgp_pkg
module tgp_back #(
  parameter int MAX_TILES = 16,
  parameter int MAX_COLS  = 8,
  parameter int MAX_ROWS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  tgp_pkg::list_cmd_t cmd,
  input  logic [3:0]         cols_set,
  input  logic [4:0]         rows_set,
  input  tgp_pkg::tile_t     tiles [MAX_TILES],
  output logic               busy,
  output logic               strobe,
  output logic [7:0]         out_tag,
  output logic [3:0]         out_row,
  output logic [2:0]         out_col,
  output logic [4:0]         out_row_span,
  output logic [3:0]         out_col_span,
  output logic [3:0]         grid_cols,
  output logic [4:0]         grid_rows,
  output logic               no_room,
  output logic               last_out
);
  import tgp_pkg::*;
  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQRT  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_GROW  = 7'b0001000,
    S_CLEAR = 7'b0010000,
    S_EXPL  = 7'b0100000,
    S_AUTO  = 7'b1000000
  } state_t;

  state_t state;
  logic [6:0] n;
  logic [7:0] cols, rows;
  logic [7:0] acc;
  logic [TW:0] idx;
  logic [RW:0] r;
  logic [7:0]  c;
  logic [MAX_TILES-1:0] defer;
  logic [MAX_COLS-1:0]  occ [MAX_ROWS];
  logic [RW:0] clr;

  tile_t t;
  logic [7:0] cs, rs, wr, wc;
  logic [MAX_COLS-1:0] mask;
  logic fits;

  assign t    = tiles[idx[TW-1:0]];
  assign rs   = 8'(t.rspan);
  assign cs   = (8'(t.cspan) > cols) ? cols : 8'(t.cspan);
  assign wr   = 8'(signed'(t.row));
  assign wc   = 8'(signed'(t.col));

  // area test at position (pr, pc); rows checked in parallel
  function automatic logic area_ok(input logic [7:0] pr, input logic [7:0] pc);
    logic ok;
    logic [MAX_COLS-1:0] m;
    ok = 1'b1;
    m = MAX_COLS'(((64'd1 << cs) - 64'd1) << pc);
    if (pr[7] || pc[7] || 9'(pr) + 9'(rs) > 9'(MAX_ROWS) || 9'(pc) + 9'(cs) > 9'(cols))
      ok = 1'b0;
    else
      for (int i = 0; i < MAX_ROWS; i++)
        if (i >= 32'(pr) && i < 32'(pr) + 32'(rs) && (occ[i] & m) != '0) ok = 1'b0;
    return ok;
  endfunction

  logic [7:0] pr, pc;
  always_comb begin
    pr = (state == S_EXPL) ? wr : 8'(r);
    pc = (state == S_EXPL) ? wc : c;
    mask = MAX_COLS'(((64'd1 << cs) - 64'd1) << pc);
    fits = area_ok(pr, pc);
  end

  logic more_idx;
  assign more_idx = (8'(idx) + 8'd1) < 8'(n);

  // explicit position taken as asked, and last deferred tile in the first-fit pass
  logic exp_ok;
  logic auto_last;
  assign exp_ok    = !wr[7] && !wc[7] && fits;
  assign auto_last = (defer & ~(MAX_TILES'(1) << idx[TW-1:0])) == '0;

  assign busy = (state != S_IDLE);

  // sequencer: sizing, clear sweep, explicit pass, first-fit pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd.go && cmd.count != '0) begin
            n     <= cmd.count;
            cols  <= 8'd1;
            state <= (cols_set != 4'd0) ? S_DIV : S_SQRT;
            if (cols_set != 4'd0)
              cols <= (8'(cols_set) > 8'(MAX_COLS)) ? 8'(MAX_COLS) : 8'(cols_set);
            rows  <= 8'd0;
            acc   <= 8'd0;
          end
        end
        S_SQRT: begin
          if (16'(cols) * 16'(cols) < 16'(n)) cols <= cols + 8'd1;
          else begin
            if (cols > 8'(MAX_COLS)) cols <= 8'(MAX_COLS);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // rows_set if nonzero, else ceil(n/cols) by repeated addition
          if (rows_set != 5'd0) begin
            rows  <= (8'(rows_set) > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : 8'(rows_set);
            idx   <= '0;
            state <= S_GROW;
          end else if (acc < 8'(n)) begin
            acc  <= acc + cols;
            rows <= rows + 8'd1;
          end else begin
            if (rows > 8'(MAX_ROWS)) rows <= 8'(MAX_ROWS);
            idx   <= '0;
            state <= S_GROW;
          end
        end
        S_GROW: begin
          if (!wc[7] && wc + 8'(t.cspan) > cols) cols <= wc + 8'(t.cspan);
          if (!wr[7] && wr + rs > rows) rows <= wr + rs;
          if (more_idx) idx <= idx + 1'b1;
          else begin
            clr   <= '0;
            state <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (cols > 8'(MAX_COLS)) cols <= 8'(MAX_COLS);
          if (rows > 8'(MAX_ROWS)) rows <= 8'(MAX_ROWS);
          occ[clr[RW-1:0]] <= '0;
          if (32'(clr) == MAX_ROWS - 1) begin
            idx   <= '0;
            defer <= '0;
            state <= S_EXPL;
          end else clr <= clr + 1'b1;
        end
        S_EXPL: begin
          if (exp_ok) begin
            for (int i = 0; i < MAX_ROWS; i++)
              if (i >= 32'(wr) && i < 32'(wr) + 32'(rs)) occ[i] <= occ[i] | mask;
            strobe       <= 1'b1;
            out_tag      <= t.tag;
            out_row      <= 4'(wr);
            out_col      <= 3'(wc);
            out_row_span <= t.rspan;
            out_col_span <= 4'(cs);
            grid_cols    <= 4'(cols);
            grid_rows    <= 5'(rows);
            no_room      <= 1'b0;
            last_out     <= !more_idx && (defer == '0);
          end else defer[idx[TW-1:0]] <= 1'b1;
          r <= '0;
          c <= '0;
          if (more_idx) idx <= idx + 1'b1;
          else begin
            idx   <= '0;
            // nothing deferred: the list ends here
            state <= (exp_ok && defer == '0) ? S_IDLE : S_AUTO;
          end
        end
        S_AUTO: begin
          if (!defer[idx[TW-1:0]]) begin
            if (more_idx) idx <= idx + 1'b1;
            else state <= S_IDLE;
          end else if (fits || 9'(r) + 9'(rs) > 9'(MAX_ROWS)) begin
            if (fits)
              for (int i = 0; i < MAX_ROWS; i++)
                if (i >= 32'(r) && i < 32'(r) + 32'(rs)) occ[i] <= occ[i] | mask;
            defer[idx[TW-1:0]] <= 1'b0;
            strobe       <= 1'b1;
            out_tag      <= t.tag;
            out_row      <= fits ? 4'(r) : 4'd0;
            out_col      <= fits ? 3'(c) : 3'd0;
            out_row_span <= t.rspan;
            out_col_span <= 4'(cs);
            grid_cols    <= 4'(cols);
            grid_rows    <= 5'(rows);
            no_room      <= !fits;
            last_out     <= auto_last;
            r <= '0;
            c <= '0;
            if (more_idx && !auto_last) idx <= idx + 1'b1;
            else state <= S_IDLE;
          end else if (c + cs + 8'd1 <= cols) c <= c + 8'd1;
          else begin
            c <= '0;
            r <= r + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy)) else $error("result outside a list");
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |=> !strobe) else $error("result from idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && last_out) |-> (state == S_IDLE)) else $error("last result not final");
`endif
endmodule

### hdl/tile_grid_placement_core.sv
// tiles load one per cycle while busy is low; after the last tile the grid is sized,
// the occupancy map is cleared row by row, then explicit tiles are placed as asked
// and deferred tiles are placed first-fit by probing positions in turn.
// busy is high from the cycle after the last tile until the final result.
// results cannot be stalled; synchronous reset clears control, fill count and config
module tile_grid_placement_core #(
  parameter int MAX_TILES = 16,
  parameter int MAX_COLS  = 8,
  parameter int MAX_ROWS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic [7:0] tile_tag,
  input  logic       tile_active,
  input  logic [4:0] want_row,
  input  logic [3:0] want_col,
  input  logic [4:0] row_span,
  input  logic [3:0] col_span,
  input  logic       last_tile,
  output logic       strobe,
  output logic [7:0] out_tag,
  output logic [3:0] out_row,
  output logic [2:0] out_col,
  output logic [4:0] out_row_span,
  output logic [3:0] out_col_span,
  output logic [3:0] grid_cols,
  output logic [4:0] grid_rows,
  output logic       no_room,
  output logic       last_out
);
  import tgp_pkg::*;
  localparam int CW = $clog2(MAX_TILES+1);
  localparam int TW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

  logic [3:0] cols_set;
  logic [4:0] rows_set;
  logic wr_en;
  logic [CW-1:0] wr_addr;
  tile_t wr_data;
  list_cmd_t cmd;
  tile_t tiles [MAX_TILES];
  logic back_busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_set <= '0;
      rows_set <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_GRID_COLS) cols_set <= cfg_data[3:0];
      else rows_set <= cfg_data;
    end
  end

  assign busy = back_busy || cmd.go;

  // tile store
  always_ff @(posedge clk) begin
    if (wr_en) tiles[wr_addr[TW-1:0]] <= wr_data;
  end

  tgp_front #(.MAX_TILES(MAX_TILES)) u_front (
    .clk, .rst, .take(start && !busy), .tile_tag, .tile_active, .want_row, .want_col,
    .row_span, .col_span, .last_tile, .wr_en, .wr_addr, .wr_data, .cmd
  );

  tgp_back #(.MAX_TILES(MAX_TILES), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk, .rst, .cmd, .cols_set, .rows_set, .tiles, .busy(back_busy), .strobe,
    .out_tag, .out_row, .out_col, .out_row_span, .out_col_span, .grid_cols,
    .grid_rows, .no_room, .last_out
  );
endmodule
